/* hdl/assert_macros.svh */
// Assertion macros shared by the checker files of the resampler.
// Each macro expects a signal named clk in the scope of use; SLRV_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define SLRV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define SLRV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/slrv_pkg.sv */
// Package of the stereo linear resampler: widths, constants, types and helpers.
// No dependencies; the design and checker files refer to it by scoped names.
`timescale 1ns / 1ps

package slrv_pkg;

  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_OUTPUTS     = 4;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 3;
  localparam int SAMPLE_W        = 16;
  localparam int DIFF_W          = SAMPLE_W + 1;
  localparam int VOL_W           = 4;
  localparam int CNT_W           = $clog2(MAX_OUTPUTS) + 1;
  localparam int MUL_A_W         = DIFF_W;
  localparam int MUL_B_W         = PHASE_FRAC_BITS + 1;
  localparam int MUL_P_W         = MUL_A_W + MUL_B_W;
  localparam int DATA_W          = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int REG_IDX_LSB     = 2;
  localparam int VOL_UNITY       = 8;
  localparam int VOL_SHIFT       = $clog2(VOL_UNITY);

  localparam logic [PHASE_W-1:0] PHASE_ONE   = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PHASE_W-1:0] RATIO_MIN   =
    PHASE_W'((2 ** PHASE_FRAC_BITS + MAX_OUTPUTS - 1) / MAX_OUTPUTS);
  localparam logic [PHASE_W-1:0] RATIO_MAX   = PHASE_W'(4 * (2 ** PHASE_FRAC_BITS));
  localparam logic [PHASE_W-1:0] RATIO_RESET = PHASE_W'(60211);
  localparam logic [VOL_W-1:0]   VOL_RESET   = VOL_W'(VOL_UNITY);

  localparam logic [MUL_P_W-1:0] FRAC_MASK = (MUL_P_W'(1) << PHASE_FRAC_BITS) - MUL_P_W'(1);
  localparam logic [MUL_P_W-1:0] VOL_MASK  = (MUL_P_W'(1) << VOL_SHIFT) - MUL_P_W'(1);

  typedef enum logic [0:0] {
    REG_STEP_RATIO    = 1'b0,
    REG_OUTPUT_VOLUME = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LMUL,
    S_LSUM,
    S_LVOL,
    S_RMUL,
    S_RSUM,
    S_RVOL,
    S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [PHASE_W-1:0] ratio;
    logic [VOL_W-1:0]   volume;
  } cfg_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } mul_req_t;

  // Offset of an interpolated sample: product over one phase unit, towards zero.
  function automatic logic signed [DIFF_W-1:0] lerp_offset(
    input logic signed [MUL_P_W-1:0] p
  );
    logic [MUL_P_W-1:0] adj;
    adj = p + (p[MUL_P_W-1] ? FRAC_MASK : '0);
    return adj[PHASE_FRAC_BITS +: DIFF_W];
  endfunction

  // Volume product divided by unity gain, towards zero.
  function automatic logic signed [SAMPLE_W-1:0] vol_scale(
    input logic signed [MUL_P_W-1:0] p
  );
    logic [MUL_P_W-1:0] adj;
    adj = p + (p[MUL_P_W-1] ? VOL_MASK : '0);
    return adj[VOL_SHIFT +: SAMPLE_W];
  endfunction

endpackage

/* hdl/slrv_channels.sv */
// Handshake channel interfaces for input frames and output samples.
// Depends on slrv_pkg for the sample width.
`timescale 1ns / 1ps

interface slrv_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slrv_pkg::SAMPLE_W-1:0]   left_sample;
  logic signed [slrv_pkg::SAMPLE_W-1:0]   right_sample;
  logic                                   restart;

  modport source (output valid, output left_sample, output right_sample,
                  output restart, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input restart, output ready);
endinterface

interface slrv_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [slrv_pkg::SAMPLE_W-1:0]   out_left;
  logic signed [slrv_pkg::SAMPLE_W-1:0]   out_right;
  logic                                   last_of_run;

  modport source (output valid, output out_left, output out_right,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_left, input out_right,
                  input last_of_run, output ready);
endinterface

/* hdl/stereo_linear_resampler_with_volume.sv */
// Top level of the stereo linear resampler with volume.
// Depends on slrv_pkg, the channel interfaces, slrv_cfg_regs, slrv_mul_unit and slrv_seq.
//
//   Channel   Direction  Handshake             Payload
//   in_ch     sink       valid / ready         left_sample, right_sample, restart
//   out_ch    source     valid / ready         out_left, out_right, last_of_run
//   cfg (APB) slave      psel, penable, pready step_ratio at 0x0, output_volume at 0x4
//
// An item gives from 0 to 4 results.
// Each result steps through LMUL, LSUM, LVOL, RMUL, RSUM, RVOL and EMIT, as one multiplier
// serves both channels, once for the interpolation and once for the volume of each.
// A frame that starts a stream, or one that gives no result, is handled in IDLE and the block stays ready.
// Reset is synchronous: it clears the held frame, the phase and the output valid flag.
// The sequencer waits with a finished result while the output register is full and not being taken.
`timescale 1ns / 1ps

module stereo_linear_resampler_with_volume (
  input  logic                            clk,
  input  logic                            rst_n,
  slrv_in_if.sink                         in_ch,
  slrv_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slrv_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slrv_pkg::DATA_W-1:0]     pwdata,
  output logic [slrv_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);

  slrv_pkg::cfg_t                      cfg;
  slrv_pkg::mul_req_t                  mul_req;
  logic signed [slrv_pkg::MUL_P_W-1:0] prod;

  slrv_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  slrv_mul_unit u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  slrv_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg     (cfg),
    .mul_req (mul_req),
    .prod    (prod)
  );

endmodule

/* hdl/slrv_cfg_regs.sv */
// Configuration registers behind the APB-style port, with ratio saturation.
// Depends on slrv_pkg.
`timescale 1ns / 1ps

module slrv_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slrv_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [slrv_pkg::DATA_W-1:0]       pwdata,
  output logic [slrv_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  output slrv_pkg::cfg_t                    cfg
);

  logic [slrv_pkg::PHASE_W-1:0] ratio_r;
  logic [slrv_pkg::PHASE_W-1:0] ratio_nxt;
  logic [slrv_pkg::VOL_W-1:0]   volume_r;
  logic [slrv_pkg::VOL_W-1:0]   volume_nxt;
  slrv_pkg::reg_idx_t           idx;
  logic                         wr_en;

  assign idx    = slrv_pkg::reg_idx_t'(paddr[slrv_pkg::REG_IDX_LSB]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    ratio_nxt  = ratio_r;
    volume_nxt = volume_r;
    prdata     = '0;
    case (idx)
      slrv_pkg::REG_STEP_RATIO: begin
        prdata = slrv_pkg::DATA_W'(ratio_r);
        if (wr_en) begin
          ratio_nxt = pwdata[slrv_pkg::PHASE_W-1:0];
        end
      end
      slrv_pkg::REG_OUTPUT_VOLUME: begin
        prdata = slrv_pkg::DATA_W'(volume_r);
        if (wr_en) begin
          volume_nxt = pwdata[slrv_pkg::VOL_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= slrv_pkg::RATIO_RESET;
      volume_r <= slrv_pkg::VOL_RESET;
    end else begin
      ratio_r  <= ratio_nxt;
      volume_r <= volume_nxt;
    end
  end

  always_comb begin
    cfg.volume = volume_r;
    if (ratio_r < slrv_pkg::RATIO_MIN) begin
      cfg.ratio = slrv_pkg::RATIO_MIN;
    end else if (ratio_r > slrv_pkg::RATIO_MAX) begin
      cfg.ratio = slrv_pkg::RATIO_MAX;
    end else begin
      cfg.ratio = ratio_r;
    end
  end

endmodule

/* hdl/slrv_mul_unit.sv */
// Shared signed multiplier with a registered product.
// Depends on slrv_pkg for the operand and product widths.
`timescale 1ns / 1ps

module slrv_mul_unit (
  input  logic                                clk,
  input  slrv_pkg::mul_req_t                  req,
  output logic signed [slrv_pkg::MUL_P_W-1:0] prod_r
);

  logic signed [slrv_pkg::MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = req.a * req.b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* hdl/slrv_seq.sv */
// Sequencer and datapath registers: held frame, phase, run count and output register.
// Depends on slrv_pkg and the channel interfaces; drives the shared multiplier.
`timescale 1ns / 1ps

module slrv_seq (
  input  logic                                clk,
  input  logic                                rst_n,
  slrv_in_if.sink                             in_ch,
  slrv_out_if.source                          out_ch,
  input  slrv_pkg::cfg_t                      cfg,
  output slrv_pkg::mul_req_t                  mul_req,
  input  logic signed [slrv_pkg::MUL_P_W-1:0] prod
);

  localparam int SW = slrv_pkg::SAMPLE_W;
  localparam int PW = slrv_pkg::PHASE_W;
  localparam int FB = slrv_pkg::PHASE_FRAC_BITS;
  localparam int CW = slrv_pkg::CNT_W;

  slrv_pkg::seq_state_t state_r, state_nxt;

  logic signed [SW-1:0]            held_left_r, held_left_nxt;
  logic signed [SW-1:0]            held_right_r, held_right_nxt;
  logic                            held_valid_r, held_valid_nxt;
  logic [PW-1:0]                   phase_r, phase_nxt;
  logic [CW-1:0]                   cnt_r, cnt_nxt;
  logic signed [SW-1:0]            new_left_r, new_left_nxt;
  logic signed [SW-1:0]            new_right_r, new_right_nxt;
  logic signed [SW:0]              diff_left_r, diff_left_nxt;
  logic signed [SW:0]              diff_right_r, diff_right_nxt;
  logic signed [SW-1:0]            lerp_r, lerp_nxt;
  logic signed [SW-1:0]            res_left_r, res_left_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]            out_left_r, out_left_nxt;
  logic signed [SW-1:0]            out_right_r, out_right_nxt;
  logic                            out_last_r, out_last_nxt;

  logic                            in_acc;
  logic                            out_free;
  logic signed [SW-1:0]            scaled;
  logic signed [SW:0]              held_sel_ext;
  logic signed [SW:0]              lerp_sum;
  logic [PW-1:0]                   phase_sum;
  logic [CW-1:0]                   cnt_inc;
  logic                            more;
  logic signed [SW:0]              in_left_ext;
  logic signed [SW:0]              in_right_ext;
  logic [slrv_pkg::MUL_B_W-1:0]    frac_op;
  logic [slrv_pkg::MUL_B_W-1:0]    vol_op;
  logic signed [slrv_pkg::MUL_A_W-1:0] lerp_op;

  assign in_ch.ready        = (state_r == slrv_pkg::S_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign out_free           = !out_valid_r || out_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_left    = out_left_r;
  assign out_ch.out_right   = out_right_r;
  assign out_ch.last_of_run = out_last_r;

  assign in_left_ext  = {in_ch.left_sample[SW-1], in_ch.left_sample};
  assign in_right_ext = {in_ch.right_sample[SW-1], in_ch.right_sample};
  assign frac_op      = {1'b0, phase_r[FB-1:0]};
  assign vol_op       = {{(slrv_pkg::MUL_B_W - slrv_pkg::VOL_W){1'b0}}, cfg.volume};
  assign lerp_op      = {{(slrv_pkg::MUL_A_W - SW){lerp_r[SW-1]}}, lerp_r};
  assign scaled       = (cfg.volume >= slrv_pkg::VOL_W'(slrv_pkg::VOL_UNITY)) ?
                        lerp_r : slrv_pkg::vol_scale(prod);
  assign held_sel_ext = (state_r == slrv_pkg::S_LSUM) ?
                        {held_left_r[SW-1], held_left_r} : {held_right_r[SW-1], held_right_r};
  assign lerp_sum     = held_sel_ext + slrv_pkg::lerp_offset(prod);
  assign phase_sum    = phase_r + cfg.ratio;
  assign cnt_inc      = cnt_r + CW'(1);
  assign more         = (phase_sum < slrv_pkg::PHASE_ONE) &&
                        (cnt_inc < CW'(slrv_pkg::MAX_OUTPUTS));

  always_comb begin
    state_nxt      = state_r;
    held_left_nxt  = held_left_r;
    held_right_nxt = held_right_r;
    held_valid_nxt = held_valid_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    new_left_nxt   = new_left_r;
    new_right_nxt  = new_right_r;
    diff_left_nxt  = diff_left_r;
    diff_right_nxt = diff_right_r;
    lerp_nxt       = lerp_r;
    res_left_nxt   = res_left_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_last_nxt   = out_last_r;
    mul_req.a      = diff_left_r;
    mul_req.b      = frac_op;

    case (state_r)
      slrv_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.restart || !held_valid_r) begin
            held_left_nxt  = in_ch.left_sample;
            held_right_nxt = in_ch.right_sample;
            held_valid_nxt = 1'b1;
            if (in_ch.restart) begin
              phase_nxt = '0;
            end
          end else if (phase_r < slrv_pkg::PHASE_ONE) begin
            new_left_nxt   = in_ch.left_sample;
            new_right_nxt  = in_ch.right_sample;
            diff_left_nxt  = in_left_ext - {held_left_r[SW-1], held_left_r};
            diff_right_nxt = in_right_ext - {held_right_r[SW-1], held_right_r};
            cnt_nxt        = '0;
            state_nxt      = slrv_pkg::S_LMUL;
          end else begin
            phase_nxt      = phase_r - slrv_pkg::PHASE_ONE;
            held_left_nxt  = in_ch.left_sample;
            held_right_nxt = in_ch.right_sample;
          end
        end
      end
      slrv_pkg::S_LMUL: begin
        mul_req.a = diff_left_r;
        mul_req.b = frac_op;
        state_nxt = slrv_pkg::S_LSUM;
      end
      slrv_pkg::S_LSUM: begin
        lerp_nxt  = lerp_sum[SW-1:0];
        state_nxt = slrv_pkg::S_LVOL;
      end
      slrv_pkg::S_LVOL: begin
        mul_req.a = lerp_op;
        mul_req.b = vol_op;
        state_nxt = slrv_pkg::S_RMUL;
      end
      slrv_pkg::S_RMUL: begin
        res_left_nxt = scaled;
        mul_req.a    = diff_right_r;
        mul_req.b    = frac_op;
        state_nxt    = slrv_pkg::S_RSUM;
      end
      slrv_pkg::S_RSUM: begin
        lerp_nxt  = lerp_sum[SW-1:0];
        state_nxt = slrv_pkg::S_RVOL;
      end
      slrv_pkg::S_RVOL: begin
        mul_req.a = lerp_op;
        mul_req.b = vol_op;
        state_nxt = slrv_pkg::S_EMIT;
      end
      slrv_pkg::S_EMIT: begin
        mul_req.a = lerp_op;
        mul_req.b = vol_op;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = res_left_r;
          out_right_nxt = scaled;
          out_last_nxt  = !more;
          if (more) begin
            phase_nxt = phase_sum;
            cnt_nxt   = cnt_inc;
            state_nxt = slrv_pkg::S_LMUL;
          end else begin
            phase_nxt      = (phase_sum >= slrv_pkg::PHASE_ONE) ?
                             (phase_sum - slrv_pkg::PHASE_ONE) : phase_sum;
            held_left_nxt  = new_left_r;
            held_right_nxt = new_right_r;
            state_nxt      = slrv_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = slrv_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= slrv_pkg::S_IDLE;
      held_left_r  <= '0;
      held_right_r <= '0;
      held_valid_r <= 1'b0;
      phase_r      <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_left_r  <= held_left_nxt;
      held_right_r <= held_right_nxt;
      held_valid_r <= held_valid_nxt;
      phase_r      <= phase_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_left_r   <= new_left_nxt;
    new_right_r  <= new_right_nxt;
    diff_left_r  <= diff_left_nxt;
    diff_right_r <= diff_right_nxt;
    lerp_r       <= lerp_nxt;
    res_left_r   <= res_left_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

/* hdl/slrv_checker.sv */
// Port-level checker for the resampler, bound to the top level.
// Depends on assert_macros.svh and slrv_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slrv_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [slrv_pkg::SAMPLE_W-1:0] out_left,
  input logic signed [slrv_pkg::SAMPLE_W-1:0] out_right,
  input logic                                out_last
);

  // A waiting result holds still until it is taken.
  `SLRV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right) && $stable(out_last), "output item changed while stalled")

  // While a run still has results to come, no new frame is taken.
  `SLRV_ASSERT(a_busy_mid_run, out_valid && out_ready && !out_last |-> !in_ready, "input ready in the middle of a run")

  // No result can appear the cycle after a frame is taken.
  `SLRV_ASSERT(a_no_early_out, in_valid && in_ready |=> !$rose(out_valid), "result appeared too early")

  // Reset leaves the block ready and with no result pending.
  `SLRV_ASSERT_RST(a_reset_idle, !rst_n |=> in_ready && !out_valid, "block not idle after reset")

endmodule

bind stereo_linear_resampler_with_volume slrv_checker u_slrv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.out_left),
  .out_right (out_ch.out_right),
  .out_last  (out_ch.last_of_run)
);
